/* hdl/wpb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wpb_pkg;

	// storage geometry
	localparam int MAX_BINS     = 2048;
	localparam int NUM_CHANNELS = 2;
	localparam int BIN_W        = $clog2(MAX_BINS);
	localparam int CH_W         = $clog2(NUM_CHANNELS);
	localparam int ADDR_W       = BIN_W + CH_W;
	localparam int DEPTH        = NUM_CHANNELS * MAX_BINS;

	// field and register widths
	localparam int MODE_W     = 2;
	localparam int GW_W       = 12;
	localparam int SPC_W      = 32;
	localparam int HH_W       = 9;
	localparam int CHAN_W     = 3;
	localparam int IDX_W      = 32;
	localparam int SMP_W      = 32;
	localparam int SEL_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// shared divider
	localparam int PROD_W    = IDX_W + GW_W;
	localparam int DIVQ_W    = PROD_W;
	localparam int DIVR_W    = 32;
	localparam int DIV_CNT_W = $clog2(DIVQ_W);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPC   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF  = 2'd3;

	// register reset values
	localparam logic [MODE_W-1:0] MODE_RST  = 2'd1;
	localparam logic [GW_W-1:0]   WIDTH_RST = 12'd1024;
	localparam logic [SPC_W-1:0]  SPC_RST   = 32'd1;
	localparam logic [HH_W-1:0]   HALF_RST  = 9'd100;

	// sample width codes; any other code means 32-bit
	localparam logic [MODE_W-1:0] MODE_8BIT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_16BIT = 2'd1;

	// operation codes
	localparam logic OP_STORE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_POS_START,
		ST_POS_WAIT,
		ST_BIN_READ,
		ST_BIN_WRITE,
		ST_RD_READ,
		ST_SCALE_START,
		ST_SCALE_WAIT,
		ST_HEIGHT_START,
		ST_HEIGHT_WAIT,
		ST_RESULT
	} wpb_state_t;

	typedef enum logic [1:0] {
		DIV_POS,
		DIV_SCALE,
		DIV_HEIGHT
	} wpb_div_sel_t;

	typedef struct packed {
		logic         take;
		logic         mul;
		logic         div_start;
		wpb_div_sel_t div_sel;
		logic         mem_rd;
		logic         bin_write;
		logic         clear_we;
		logic         load_result;
	} wpb_cmd_t;

	typedef struct packed {
		logic req_read;
		logic req_chan_ok;
		logic div_done;
		logic clear_last;
		logic out_free;
	} wpb_sts_t;

	function automatic logic signed [SMP_W-1:0] sign_extend(
		input logic [MODE_W-1:0] mode,
		input logic [SMP_W-1:0]  raw
	);
		logic signed [SMP_W-1:0] v;
		case (mode)
			MODE_8BIT:  v = {{24{raw[7]}}, raw[7:0]};
			MODE_16BIT: v = {{16{raw[15]}}, raw[15:0]};
			default:    v = raw;
		endcase
		return v;
	endfunction

	// most negative value comes out as 2^31
	function automatic logic [SMP_W-1:0] magnitude(input logic signed [SMP_W-1:0] v);
		logic [SMP_W-1:0] m;
		if (v[SMP_W-1]) begin
			m = ~v + 1'b1;
		end else begin
			m = v;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

/* hdl/waveform_peak_binner.sv */
// Peak envelope binner for a two-channel PCM stream.
// Input channel (in_valid/in_ready): one item is either a store of one raw
// sample (sign-extended per sample_width_mode, mapped to bin
// sample_index*width/samples_per_channel, clamped to the last bin) or a read
// of one bin. Stores update the bin's signed peak and the channel maximum
// and produce no result; a store on channel 2..7 is dropped.
// Output channel (out_valid/out_ready): one item per read with the bin
// peak, bar height, sign flag and channel maximum.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; write only
// while the block is idle.
// Work: all divisions run through one serial divider, one quotient bit per
// cycle. A store multiplies, divides for its bin position, then reads and
// writes the bin; a read fetches its bin and runs two divisions (scale, then
// height) before its result is loaded. A read on an invalid channel skips
// both and returns zeros. No new item is taken until the last one is done.
// Reset: configuration returns to its defaults and a clearing sweep zeroes
// the 4096-entry peak memory, one entry per cycle; in_ready stays low until
// the sweep ends.
// Stall: the result waits in an output register; the next item may be accepted
// meanwhile, and a later read holds in its last state until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module waveform_peak_binner (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              operation,
	input  wire logic [wpb_pkg::CHAN_W-1:0]        channel,
	input  wire logic [wpb_pkg::IDX_W-1:0]         sample_index,
	input  wire logic [wpb_pkg::SMP_W-1:0]         raw_sample,
	input  wire logic [wpb_pkg::SEL_W-1:0]         bin_select,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [wpb_pkg::SMP_W-1:0]       bin_peak,
	output logic [wpb_pkg::HH_W-1:0]               bar_height,
	output logic                                   bar_negative,
	output logic [wpb_pkg::SMP_W-1:0]              channel_peak,
	input  wire logic                              cfg_we,
	input  wire logic [wpb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [wpb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	// controller issues one command word per cycle, datapath answers status
	wpb_pkg::wpb_cmd_t cmd;
	wpb_pkg::wpb_sts_t sts;

	wpb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// datapath holds config, memory, divider and the result register
	wpb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.channel      (channel),
		.sample_index (sample_index),
		.raw_sample   (raw_sample),
		.bin_select   (bin_select),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.bin_peak     (bin_peak),
		.bar_height   (bar_height),
		.bar_negative (bar_negative),
		.channel_peak (channel_peak)
	);

endmodule

`default_nettype wire

/* hdl/wpb_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module wpb_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [wpb_pkg::DIVQ_W-1:0]  dividend,
	input  wire logic [wpb_pkg::DIVR_W-1:0]  divisor,
	output logic                             done,
	output logic [wpb_pkg::DIVQ_W-1:0]       quotient
);

	logic [wpb_pkg::DIVQ_W-1:0]    quo_q;
	logic [wpb_pkg::DIVR_W-1:0]    rem_q;
	logic [wpb_pkg::DIVR_W-1:0]    dvs_q;
	logic [wpb_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic [wpb_pkg::DIVR_W:0]      shifted;
	logic [wpb_pkg::DIVR_W:0]      diff;
	logic                          fits;

	assign shifted  = {rem_q, quo_q[wpb_pkg::DIVQ_W-1]};
	assign diff     = shifted - {1'b0, dvs_q};
	assign fits     = shifted >= {1'b0, dvs_q};
	assign done     = busy_q && (cnt_q == wpb_pkg::DIV_CNT_W'(wpb_pkg::DIVQ_W - 1));
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !done;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[wpb_pkg::DIVQ_W-2:0], fits};
			rem_q <= fits ? diff[wpb_pkg::DIVR_W-1:0] : shifted[wpb_pkg::DIVR_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* hdl/wpb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module wpb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire wpb_pkg::wpb_sts_t sts,
	output logic                   in_ready,
	output wpb_pkg::wpb_cmd_t      cmd
);

	wpb_pkg::wpb_state_t state_q;
	wpb_pkg::wpb_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wpb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			wpb_pkg::ST_CLEAR: begin
				if (sts.clear_last) state_d = wpb_pkg::ST_IDLE;
			end
			wpb_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (sts.req_read) begin
						state_d = sts.req_chan_ok ? wpb_pkg::ST_RD_READ : wpb_pkg::ST_RESULT;
					end else if (sts.req_chan_ok) begin
						state_d = wpb_pkg::ST_MUL;
					end
				end
			end
			wpb_pkg::ST_MUL:       state_d = wpb_pkg::ST_POS_START;
			wpb_pkg::ST_POS_START: state_d = wpb_pkg::ST_POS_WAIT;
			wpb_pkg::ST_POS_WAIT: begin
				if (sts.div_done) state_d = wpb_pkg::ST_BIN_READ;
			end
			wpb_pkg::ST_BIN_READ:    state_d = wpb_pkg::ST_BIN_WRITE;
			wpb_pkg::ST_BIN_WRITE:   state_d = wpb_pkg::ST_IDLE;
			wpb_pkg::ST_RD_READ:     state_d = wpb_pkg::ST_SCALE_START;
			wpb_pkg::ST_SCALE_START: state_d = wpb_pkg::ST_SCALE_WAIT;
			wpb_pkg::ST_SCALE_WAIT: begin
				if (sts.div_done) state_d = wpb_pkg::ST_HEIGHT_START;
			end
			wpb_pkg::ST_HEIGHT_START: state_d = wpb_pkg::ST_HEIGHT_WAIT;
			wpb_pkg::ST_HEIGHT_WAIT: begin
				if (sts.div_done) state_d = wpb_pkg::ST_RESULT;
			end
			wpb_pkg::ST_RESULT: begin
				if (sts.out_free) state_d = wpb_pkg::ST_IDLE;
			end
			default: state_d = wpb_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.div_sel = wpb_pkg::DIV_POS;
		in_ready    = 1'b0;
		case (state_q)
			wpb_pkg::ST_CLEAR: cmd.clear_we = 1'b1;
			wpb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			wpb_pkg::ST_MUL: cmd.mul = 1'b1;
			wpb_pkg::ST_POS_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = wpb_pkg::DIV_POS;
			end
			wpb_pkg::ST_BIN_READ:  cmd.mem_rd    = 1'b1;
			wpb_pkg::ST_BIN_WRITE: cmd.bin_write = 1'b1;
			wpb_pkg::ST_RD_READ:   cmd.mem_rd    = 1'b1;
			wpb_pkg::ST_SCALE_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = wpb_pkg::DIV_SCALE;
			end
			wpb_pkg::ST_HEIGHT_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = wpb_pkg::DIV_HEIGHT;
			end
			wpb_pkg::ST_RESULT: cmd.load_result = sts.out_free;
			default: cmd.take = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/wpb_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module wpb_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire wpb_pkg::wpb_cmd_t                 cmd,
	output wpb_pkg::wpb_sts_t                      sts,
	input  wire logic                              operation,
	input  wire logic [wpb_pkg::CHAN_W-1:0]        channel,
	input  wire logic [wpb_pkg::IDX_W-1:0]         sample_index,
	input  wire logic [wpb_pkg::SMP_W-1:0]         raw_sample,
	input  wire logic [wpb_pkg::SEL_W-1:0]         bin_select,
	input  wire logic                              cfg_we,
	input  wire logic [wpb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [wpb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic signed [wpb_pkg::SMP_W-1:0]       bin_peak,
	output logic [wpb_pkg::HH_W-1:0]               bar_height,
	output logic                                   bar_negative,
	output logic [wpb_pkg::SMP_W-1:0]              channel_peak
);

	// configuration
	logic [wpb_pkg::MODE_W-1:0] mode_q;
	logic [wpb_pkg::GW_W-1:0]   gw_q;
	logic [wpb_pkg::SPC_W-1:0]  spc_q;
	logic [wpb_pkg::HH_W-1:0]   hh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= wpb_pkg::MODE_RST;
			gw_q   <= wpb_pkg::WIDTH_RST;
			spc_q  <= wpb_pkg::SPC_RST;
			hh_q   <= wpb_pkg::HALF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				wpb_pkg::CFG_MODE:  mode_q <= cfg_wdata[wpb_pkg::MODE_W-1:0];
				wpb_pkg::CFG_WIDTH: gw_q   <= cfg_wdata[wpb_pkg::GW_W-1:0];
				wpb_pkg::CFG_SPC:   spc_q  <= cfg_wdata[wpb_pkg::SPC_W-1:0];
				wpb_pkg::CFG_HALF:  hh_q   <= cfg_wdata[wpb_pkg::HH_W-1:0];
				default:            mode_q <= mode_q;
			endcase
		end
	end

	// latched item
	logic                              op_q;
	logic [wpb_pkg::CH_W-1:0]          ch_q;
	logic                              ch_ok_q;
	logic [wpb_pkg::IDX_W-1:0]         idx_q;
	logic signed [wpb_pkg::SMP_W-1:0]  val_q;
	logic [wpb_pkg::BIN_W-1:0]         sel_q;
	logic                              chan_ok;

	assign chan_ok = channel < wpb_pkg::CHAN_W'(wpb_pkg::NUM_CHANNELS);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= operation;
			ch_q    <= channel[wpb_pkg::CH_W-1:0];
			ch_ok_q <= chan_ok;
			idx_q   <= sample_index;
			val_q   <= wpb_pkg::sign_extend(mode_q, raw_sample);
			sel_q   <= bin_select[wpb_pkg::BIN_W-1:0];
		end
	end

	// bins in use, limited to 1..MAX_BINS
	logic [wpb_pkg::GW_W-1:0]  w_eff;
	logic [wpb_pkg::BIN_W-1:0] w_m1;

	always_comb begin
		if (gw_q == '0) begin
			w_eff = wpb_pkg::GW_W'(1);
		end else if (gw_q > wpb_pkg::GW_W'(wpb_pkg::MAX_BINS)) begin
			w_eff = wpb_pkg::GW_W'(wpb_pkg::MAX_BINS);
		end else begin
			w_eff = gw_q;
		end
	end
	assign w_m1 = wpb_pkg::BIN_W'(w_eff - 1'b1);

	logic [wpb_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= wpb_pkg::PROD_W'(idx_q) * wpb_pkg::PROD_W'(w_eff);
	end

	// shared divider
	logic [wpb_pkg::SMP_W-1:0]  chmax_q [wpb_pkg::NUM_CHANNELS];
	logic [wpb_pkg::DIVQ_W-1:0] div_dividend;
	logic [wpb_pkg::DIVR_W-1:0] div_divisor;
	logic                       div_done;
	logic [wpb_pkg::DIVQ_W-1:0] div_quo;
	logic [wpb_pkg::DIVR_W-1:0] scale_d;
	logic [wpb_pkg::DIVR_W-1:0] scale_q;
	logic signed [wpb_pkg::SMP_W-1:0] rdata_q;

	assign scale_d = (hh_q == '0) ? '0 : div_quo[wpb_pkg::DIVR_W-1:0];

	always_comb begin
		case (cmd.div_sel)
			wpb_pkg::DIV_POS: begin
				div_dividend = prod_q;
				div_divisor  = spc_q;
			end
			wpb_pkg::DIV_SCALE: begin
				div_dividend = wpb_pkg::DIVQ_W'(chmax_q[ch_q]);
				div_divisor  = wpb_pkg::DIVR_W'(hh_q);
			end
			wpb_pkg::DIV_HEIGHT: begin
				div_dividend = wpb_pkg::DIVQ_W'(wpb_pkg::magnitude(rdata_q));
				div_divisor  = scale_d;
			end
			default: begin
				div_dividend = prod_q;
				div_divisor  = spc_q;
			end
		endcase
	end

	wpb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// hold the scale divisor for the height step
	always_ff @(posedge clk) begin
		if (cmd.div_start && cmd.div_sel == wpb_pkg::DIV_HEIGHT) scale_q <= scale_d;
	end

	// bin position, clamped to the last bin in use
	logic [wpb_pkg::BIN_W-1:0] pos_bin;

	always_comb begin
		if (spc_q == '0 || div_quo > wpb_pkg::DIVQ_W'(w_m1)) begin
			pos_bin = w_m1;
		end else begin
			pos_bin = div_quo[wpb_pkg::BIN_W-1:0];
		end
	end

	// peak memory with clearing sweep
	logic signed [wpb_pkg::SMP_W-1:0] bins_q [wpb_pkg::DEPTH];
	logic [wpb_pkg::ADDR_W-1:0]       clr_cnt_q;
	logic [wpb_pkg::ADDR_W-1:0]       mem_addr;
	logic                             mem_we;
	logic signed [wpb_pkg::SMP_W-1:0] mem_wdata;
	logic signed [wpb_pkg::SMP_W-1:0] new_peak;

	always_comb begin
		if (cmd.clear_we) begin
			mem_addr = clr_cnt_q;
		end else if (op_q == wpb_pkg::OP_READ) begin
			mem_addr = {ch_q, sel_q};
		end else begin
			mem_addr = {ch_q, pos_bin};
		end
	end

	always_comb begin
		new_peak = rdata_q;
		if (val_q > 0) begin
			if (val_q > rdata_q) new_peak = val_q;
		end else if (rdata_q <= 0 && val_q < rdata_q) begin
			new_peak = val_q;
		end
	end

	assign mem_we    = cmd.clear_we || cmd.bin_write;
	assign mem_wdata = cmd.clear_we ? '0 : new_peak;

	always_ff @(posedge clk) begin
		if (mem_we) bins_q[mem_addr] <= mem_wdata;
		if (cmd.mem_rd) rdata_q <= bins_q[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_we) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// per-channel maximum magnitude
	logic [wpb_pkg::SMP_W-1:0] val_mag;

	assign val_mag = wpb_pkg::magnitude(val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < wpb_pkg::NUM_CHANNELS; c++) begin
				chmax_q[c] <= '0;
			end
		end else if (cmd.bin_write && val_mag > chmax_q[ch_q]) begin
			chmax_q[ch_q] <= val_mag;
		end
	end

	// result register
	logic                             out_valid_q;
	logic signed [wpb_pkg::SMP_W-1:0] res_peak_q;
	logic [wpb_pkg::HH_W-1:0]         res_height_q;
	logic                             res_neg_q;
	logic [wpb_pkg::SMP_W-1:0]        res_chpk_q;
	logic [wpb_pkg::HH_W-1:0]         height;

	always_comb begin
		if (!ch_ok_q || scale_q == '0) begin
			height = '0;
		end else if (div_quo > wpb_pkg::DIVQ_W'(hh_q)) begin
			height = hh_q;
		end else begin
			height = div_quo[wpb_pkg::HH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_peak_q   <= ch_ok_q ? rdata_q : '0;
			res_neg_q    <= ch_ok_q && rdata_q[wpb_pkg::SMP_W-1];
			res_chpk_q   <= ch_ok_q ? chmax_q[ch_q] : '0;
			res_height_q <= height;
		end
	end

	assign out_valid    = out_valid_q;
	assign bin_peak     = res_peak_q;
	assign bar_height   = res_height_q;
	assign bar_negative = res_neg_q;
	assign channel_peak = res_chpk_q;

	assign sts.req_read    = operation == wpb_pkg::OP_READ;
	assign sts.req_chan_ok = chan_ok;
	assign sts.div_done    = div_done;
	assign sts.clear_last  = clr_cnt_q == wpb_pkg::ADDR_W'(wpb_pkg::DEPTH - 1);
	assign sts.out_free    = !out_valid_q || out_ready;

endmodule

`default_nettype wire

/* hdl/wpb_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module wpb_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              operation,
	input wire logic [wpb_pkg::CHAN_W-1:0]        channel,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic signed [wpb_pkg::SMP_W-1:0]  bin_peak,
	input wire logic [wpb_pkg::HH_W-1:0]          bar_height,
	input wire logic                              bar_negative
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_peak) && $stable(bar_height))
		else $error("result changed while stalled");

	// sign flag follows the peak
	a_neg_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bar_negative |-> bin_peak[wpb_pkg::SMP_W-1])
		else $error("bar_negative set on non-negative peak");

	// an empty bin has no bar
	a_zero_bar: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bin_peak == '0 |-> bar_height == '0 && !bar_negative)
		else $error("bar on zero peak");

	// an item that does work keeps the input closed for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready &&
		(operation || channel < wpb_pkg::CHAN_W'(wpb_pkg::NUM_CHANNELS)) |=> !in_ready)
		else $error("input reopened during work");

endmodule

bind waveform_peak_binner wpb_chk u_wpb_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.operation    (operation),
	.channel      (channel),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.bin_peak     (bin_peak),
	.bar_height   (bar_height),
	.bar_negative (bar_negative)
);

`default_nettype wire

/* sim/waveform_peak_binner_tb.sv */
`timescale 1ns / 1ps

module waveform_peak_binner_tb;

	// width codes the package leaves unnamed; the spare code behaves as 32-bit
	localparam logic [wpb_pkg::MODE_W-1:0] MODE_32BIT = 2'd2;
	localparam logic [wpb_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam int STORE_SETTLE = 64;    // a store keeps the block busy but gives no result
	localparam int DRAIN_CYCLES = 128;   // lets the last reads finish
	localparam int HOLD_AFTER   = 20;    // results seen before the long receiver hold
	localparam int HOLD_CYCLES  = 1500;
	localparam int QUIET_FROM   = 30000; // window with no idling on either side
	localparam int QUIET_TO     = 45000;
	localparam int PHASE_ITEMS  = 110;
	localparam int LIMIT_NS     = 4_800_000;

	typedef struct packed {
		logic                         op;
		logic [wpb_pkg::CHAN_W-1:0]   ch;
		logic [wpb_pkg::IDX_W-1:0]    idx;
		logic [wpb_pkg::SMP_W-1:0]    raw;
		logic [wpb_pkg::SEL_W-1:0]    sel;
	} item_t;

	typedef struct packed {
		logic signed [wpb_pkg::SMP_W-1:0] peak;
		logic [wpb_pkg::HH_W-1:0]         height;
		logic                             neg;
		logic [wpb_pkg::SMP_W-1:0]        ch_max;
	} bin_read_t;

	// clock, reset and block ports; every input starts at a known value
	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic                             in_op = wpb_pkg::OP_STORE;
	logic [wpb_pkg::CHAN_W-1:0]       in_ch = '0;
	logic [wpb_pkg::IDX_W-1:0]        in_idx = '0;
	logic [wpb_pkg::SMP_W-1:0]        in_raw = '0;
	logic [wpb_pkg::SEL_W-1:0]        in_sel = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic signed [wpb_pkg::SMP_W-1:0] bin_peak;
	logic [wpb_pkg::HH_W-1:0]         bar_height;
	logic                             bar_negative;
	logic [wpb_pkg::SMP_W-1:0]        channel_peak;
	logic                             cfg_we = 1'b0;
	logic [wpb_pkg::CFG_IDX_W-1:0]    cfg_index = wpb_pkg::CFG_MODE;
	logic [wpb_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

	// envelope model: register copies, per-channel bins and channel maxima
	logic [wpb_pkg::MODE_W-1:0]       m_mode;
	logic [wpb_pkg::GW_W-1:0]         m_width;
	logic [wpb_pkg::SPC_W-1:0]        m_spc;
	logic [wpb_pkg::HH_W-1:0]         m_half;
	logic signed [wpb_pkg::SMP_W-1:0] env_bins [wpb_pkg::DEPTH];
	logic [wpb_pkg::SMP_W-1:0]        env_chmax [wpb_pkg::NUM_CHANNELS];

	item_t     pending[$];         // items waiting to be offered
	bin_read_t expected_reads[$];  // read results owed by the block

	int n_fail = 0;
	int n_stores = 0;
	int n_dropped = 0;
	int n_reads = 0;
	int n_offchan = 0;
	int n_results = 0;
	int n_settings = 0;
	int cycle_no = 0;
	int stall_left = 0;
	logic stall_done = 1'b0;
	wire quiet_span = (cycle_no >= QUIET_FROM) && (cycle_no < QUIET_TO);

	waveform_peak_binner u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (in_op),
		.channel      (in_ch),
		.sample_index (in_idx),
		.raw_sample   (in_raw),
		.bin_select   (in_sel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bin_peak     (bin_peak),
		.bar_height   (bar_height),
		.bar_negative (bar_negative),
		.channel_peak (channel_peak),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
	end

	// sign-extend a raw sample at the current width
	function automatic logic signed [wpb_pkg::SMP_W-1:0] widen(
			input logic [wpb_pkg::SMP_W-1:0] raw);
		logic signed [7:0]  b8;
		logic signed [15:0] b16;
		b8 = raw[7:0];
		b16 = raw[15:0];
		case (m_mode)
			wpb_pkg::MODE_8BIT:  return b8;
			wpb_pkg::MODE_16BIT: return b16;
			default:             return raw;
		endcase
	endfunction

	// the most negative value wraps to 2^31, which is the wanted unsigned magnitude
	function automatic logic [wpb_pkg::SMP_W-1:0] abs_mag(
			input logic signed [wpb_pkg::SMP_W-1:0] v);
		return (v < 0) ? wpb_pkg::SMP_W'(-v) : wpb_pkg::SMP_W'(v);
	endfunction

	// scale a sample number onto the bins in use, clamped to the last one
	function automatic logic [wpb_pkg::SEL_W-1:0] map_bin(input logic [wpb_pkg::IDX_W-1:0] idx);
		logic [wpb_pkg::GW_W-1:0] w;
		logic [63:0]              pos;
		w = m_width;
		if (w == 0) w = wpb_pkg::GW_W'(1);
		if (w > wpb_pkg::MAX_BINS) w = wpb_pkg::GW_W'(wpb_pkg::MAX_BINS);
		if (m_spc == 0) begin
			pos = w - 1;
		end else begin
			pos = (64'(idx) * w) / m_spc;
		end
		if (pos > w - 1) pos = w - 1;
		return pos[wpb_pkg::SEL_W-1:0];
	endfunction

	// advance the model by one accepted item; owe a result for every read
	function automatic void record_item(input item_t it);
		logic signed [wpb_pkg::SMP_W-1:0] v;
		logic signed [wpb_pkg::SMP_W-1:0] cur;
		logic [wpb_pkg::ADDR_W-1:0]       slot;
		logic [wpb_pkg::SMP_W-1:0]        m;
		logic [wpb_pkg::SMP_W-1:0]        div;
		logic [wpb_pkg::SMP_W-1:0]        h;
		bin_read_t                        r;
		if (it.op == wpb_pkg::OP_STORE) begin
			if (it.ch >= wpb_pkg::NUM_CHANNELS) begin
				n_dropped++;
				return;
			end
			n_stores++;
			slot = {it.ch[wpb_pkg::CH_W-1:0], map_bin(it.idx)};
			v = widen(it.raw);
			cur = env_bins[slot];
			// positive raises and replaces a negative; non-positive only deepens
			if (v > 0) begin
				if (v > cur) env_bins[slot] = v;
			end else if (cur <= 0 && v < cur) begin
				env_bins[slot] = v;
			end
			m = abs_mag(v);
			if (m > env_chmax[it.ch[wpb_pkg::CH_W-1:0]]) env_chmax[it.ch[wpb_pkg::CH_W-1:0]] = m;
			return;
		end
		n_reads++;
		r = '0;
		if (it.ch >= wpb_pkg::NUM_CHANNELS) begin
			n_offchan++;
		end else begin
			// bin_select is 11 bits, so it never passes the last bin
			r.ch_max = env_chmax[it.ch[wpb_pkg::CH_W-1:0]];
			cur = env_bins[{it.ch[wpb_pkg::CH_W-1:0], it.sel}];
			r.peak = cur;
			r.neg = cur < 0;
			if (m_half != 0) begin
				div = r.ch_max / m_half;
				if (div != 0) begin
					h = abs_mag(cur) / div;
					if (h > m_half) h = m_half;
					r.height = h[wpb_pkg::HH_W-1:0];
				end
			end
		end
		expected_reads.push_back(r);
	endfunction

	function automatic item_t mk_item(input logic op, input logic [wpb_pkg::CHAN_W-1:0] ch,
			input logic [wpb_pkg::IDX_W-1:0] idx, input logic [wpb_pkg::SMP_W-1:0] raw,
			input logic [wpb_pkg::SEL_W-1:0] sel);
		item_t it;
		it.op = op;
		it.ch = ch;
		it.idx = idx;
		it.raw = raw;
		it.sel = sel;
		return it;
	endfunction

	// mostly inside the sample count so bins get hit repeatedly
	function automatic logic [wpb_pkg::IDX_W-1:0] pick_index();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 4) return '0;
		if (r < 8) return '1;
		if (r < 10) return m_spc;
		if (m_spc == 0) return $urandom;
		return $urandom_range(m_spc, 0);
	endfunction

	function automatic logic [wpb_pkg::SMP_W-1:0] pick_sample();
		int unsigned               r;
		logic [wpb_pkg::SMP_W-1:0] s;
		r = $urandom_range(99);
		if (r < 12) begin
			case ($urandom_range(7))
				0:       return 32'h8000_0000;
				1:       return 32'h7FFF_FFFF;
				2:       return 32'h0000_0080;
				3:       return 32'h0000_007F;
				4:       return 32'h0000_8000;
				5:       return 32'h0000_7FFF;
				6:       return '0;
				default: return '1;
			endcase
		end
		if (r < 40) begin
			s = $urandom_range(300);
			return $urandom_range(1) ? -s : s;
		end
		return $urandom;
	endfunction

	function automatic item_t random_item();
		item_t it;
		it.op = ($urandom_range(99) < 35) ? wpb_pkg::OP_READ : wpb_pkg::OP_STORE;
		it.ch = ($urandom_range(99) < 12) ? wpb_pkg::CHAN_W'($urandom_range(7, 2))
			: wpb_pkg::CHAN_W'($urandom_range(1));
		it.idx = pick_index();
		it.raw = pick_sample();
		// reads mostly land on bins the stores are filling
		if ($urandom_range(99) < 70) begin
			it.sel = map_bin(pick_index());
		end else begin
			it.sel = wpb_pkg::SEL_W'($urandom_range(wpb_pkg::MAX_BINS - 1));
		end
		return it;
	endfunction

	// one register write per cycle; the caller drops the enable after the last
	task automatic write_reg(input logic [wpb_pkg::CFG_IDX_W-1:0] idx,
			input logic [wpb_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			wpb_pkg::CFG_MODE:  m_mode = val[wpb_pkg::MODE_W-1:0];
			wpb_pkg::CFG_WIDTH: m_width = val[wpb_pkg::GW_W-1:0];
			wpb_pkg::CFG_SPC:   m_spc = val[wpb_pkg::SPC_W-1:0];
			default:            m_half = val[wpb_pkg::HH_W-1:0];
		endcase
	endtask

	// wait until every item is taken and answered, then let a trailing store finish
	task automatic settle();
		while (pending.size() != 0 || in_valid || expected_reads.size() != 0) begin
			@(posedge clk);
		end
		repeat (STORE_SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input logic [wpb_pkg::MODE_W-1:0] mode,
			input logic [wpb_pkg::GW_W-1:0] width,
			input logic [wpb_pkg::SPC_W-1:0] spc, input logic [wpb_pkg::HH_W-1:0] half);
		logic [wpb_pkg::CHAN_W-1:0] ch;
		write_reg(wpb_pkg::CFG_MODE, wpb_pkg::CFG_DATA_W'(mode));
		write_reg(wpb_pkg::CFG_WIDTH, wpb_pkg::CFG_DATA_W'(width));
		write_reg(wpb_pkg::CFG_SPC, spc);
		write_reg(wpb_pkg::CFG_HALF, wpb_pkg::CFG_DATA_W'(half));
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
		// open every setting with the most negative raw word and a read of its bin
		ch = wpb_pkg::CHAN_W'($urandom_range(1));
		pending.push_back(mk_item(wpb_pkg::OP_STORE, ch, '0, 32'h8000_0000, '0));
		pending.push_back(mk_item(wpb_pkg::OP_READ, ch, $urandom, $urandom, map_bin('0)));
		repeat (PHASE_ITEMS) pending.push_back(random_item());
		settle();
	endtask

	// driver: hold an offered item until taken, then advance to the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) record_item(pending.pop_front());
			if (!in_valid || in_ready) begin
				if (pending.size() != 0 && (quiet_span || $urandom_range(99) >= 10)) begin
					in_valid <= 1'b1;
					in_op <= pending[0].op;
					in_ch <= pending[0].ch;
					in_idx <= pending[0].idx;
					in_raw <= pending[0].raw;
					in_sel <= pending[0].sel;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_read();
		bin_read_t e;
		n_results++;
		if (expected_reads.size() == 0) begin
			$error("unexpected result: bin_peak %0d, channel_peak %0d", bin_peak, channel_peak);
			n_fail++;
		end else begin
			e = expected_reads.pop_front();
			if (bin_peak !== e.peak) begin
				$error("bin_peak: expected %0d, got %0d", e.peak, bin_peak);
				n_fail++;
			end
			if (bar_height !== e.height) begin
				$error("bar_height: expected %0d, got %0d", e.height, bar_height);
				n_fail++;
			end
			if (bar_negative !== e.neg) begin
				$error("bar_negative: expected %0d, got %0d", e.neg, bar_negative);
				n_fail++;
			end
			if (channel_peak !== e.ch_max) begin
				$error("channel_peak: expected %0d, got %0d", e.ch_max, channel_peak);
				n_fail++;
			end
		end
	endtask

	// monitor: take results with random stalls, and once hold off long enough
	// for the block to back up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) check_read();
			if (!stall_done && n_results >= HOLD_AFTER) begin
				stall_done <= 1'b1;
				stall_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet_span || ($urandom_range(99) >= 10);
			end
		end
	end

	initial begin
		m_mode = wpb_pkg::MODE_RST;
		m_width = wpb_pkg::WIDTH_RST;
		m_spc = wpb_pkg::SPC_RST;
		m_half = wpb_pkg::HALF_RST;
		for (int i = 0; i < wpb_pkg::DEPTH; i++) env_bins[i] = '0;
		for (int c = 0; c < wpb_pkg::NUM_CHANNELS; c++) env_chmax[c] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// the block sweeps its bin memory before it takes the first item
		while (in_ready !== 1'b1) @(posedge clk);

		// directed part at the reset settings: 16-bit, 1024 bins, one sample per channel
		n_settings = 1;
		pending.push_back(mk_item(wpb_pkg::OP_READ, 3'd0, '0, '0, 11'd0));  // empty, zero divisor
		pending.push_back(mk_item(wpb_pkg::OP_STORE, 3'd0, '0, 32'h0000_7FFF, '0)); // largest 16-bit
		// no lowering of a positive
		pending.push_back(mk_item(wpb_pkg::OP_STORE, 3'd0, '0, 32'hFFFF_8000, '0));
		pending.push_back(mk_item(wpb_pkg::OP_STORE, 3'd0, 32'd1, 32'h0000_8000, '0));
		// positive replaces negative
		pending.push_back(mk_item(wpb_pkg::OP_STORE, 3'd0, 32'd1, 32'h0000_0001, '0));
		// zero sample, last bin
		pending.push_back(mk_item(wpb_pkg::OP_STORE, 3'd0, '1, 32'h1234_0000, '0));
		pending.push_back(mk_item(wpb_pkg::OP_STORE, 3'd1, 32'd5, 32'h0000_FFFF, '0));
		pending.push_back(mk_item(wpb_pkg::OP_STORE, 3'd1, '0, '0, '0));
		// dropped channels
		pending.push_back(mk_item(wpb_pkg::OP_STORE, 3'd7, '0, 32'h0000_7FFF, '0));
		pending.push_back(mk_item(wpb_pkg::OP_STORE, 3'd2, 32'd1, 32'h0000_8000, '0));
		pending.push_back(mk_item(wpb_pkg::OP_READ, 3'd0, '0, '0, 11'd0));  // saturated height
		pending.push_back(mk_item(wpb_pkg::OP_READ, 3'd0, '0, '0, 11'd1023));
		// divisor rounds to zero
		pending.push_back(mk_item(wpb_pkg::OP_READ, 3'd1, '0, '0, 11'd1023));
		pending.push_back(mk_item(wpb_pkg::OP_READ, 3'd1, '0, '0, 11'd0));
		pending.push_back(mk_item(wpb_pkg::OP_READ, 3'd7, '0, '0, '1));     // off channel reads zero
		pending.push_back(mk_item(wpb_pkg::OP_READ, 3'd0, '0, '0, '1));
		pending.push_back(mk_item(wpb_pkg::OP_READ, 3'd3, '1, '1, '1));
		pending.push_back(mk_item(wpb_pkg::OP_STORE, 3'd1, '0, 32'h0000_8001, '0));
		// shallower, kept
		pending.push_back(mk_item(wpb_pkg::OP_STORE, 3'd1, '0, 32'h0000_FFFE, '0));
		pending.push_back(mk_item(wpb_pkg::OP_READ, 3'd1, '0, '0, 11'd0));
		settle();

		// random part across settings, extremes first
		run_phase(wpb_pkg::MODE_8BIT, 12'd200, 32'd1000, 9'd50);
		run_phase(MODE_32BIT, 12'd2048, 32'd16, 9'd300);
		run_phase(MODE_SPARE, 12'd4095, 32'd0, 9'd0);
		run_phase(wpb_pkg::MODE_16BIT, 12'd0, 32'hFFFF_FFFF, 9'd511);
		run_phase(wpb_pkg::MODE_8BIT, 12'd7, 32'd100, 9'd1);
		run_phase(MODE_32BIT, 12'd1500, 32'd3000, 9'd200);
		repeat (2) begin
			run_phase(wpb_pkg::MODE_W'($urandom_range(3)),
				wpb_pkg::GW_W'($urandom_range(2048, 200)),
				wpb_pkg::SPC_W'($urandom_range(5000, 1)),
				wpb_pkg::HH_W'($urandom_range(300, 50)));
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_reads.size() != 0) begin
			$error("%0d read results never arrived", expected_reads.size());
			n_fail++;
		end
		$display("Coverage: %0d stores, %0d dropped stores, %0d reads (%0d off-channel)",
			n_stores, n_dropped, n_reads, n_offchan);
		$display("Coverage: %0d results checked over %0d register settings",
			n_results, n_settings);
		if (n_fail == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#(LIMIT_NS);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
